// File: rtl/bdl_pkg.sv
// Shared types, codes and helpers for the Bayer demosaic unit.
package bdl_pkg;

   // Request kinds
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // Control register indexes
   localparam logic [1:0] CSR_CFA_PATTERN  = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam int CSR_DATA_BITS = 13;
   localparam int WIDTH_REG_BITS = 12;
   localparam int HEIGHT_BITS = 13;

   localparam int MIN_SIZE = 6;
   localparam int MAX_HEIGHT = 4096;
   localparam int RESET_WIDTH = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int LINES = 5;

   typedef enum logic [1:0] {
      COLOUR_RED   = 2'd0,
      COLOUR_GREEN = 2'd1,
      COLOUR_BLUE  = 2'd2
   } colour_type;

   // Colour at each phase (row parity * 2 + column parity) for each pattern
   localparam colour_type PHASE_COLOUR [4][4] = '{
      '{COLOUR_RED,   COLOUR_GREEN, COLOUR_GREEN, COLOUR_BLUE},
      '{COLOUR_GREEN, COLOUR_RED,   COLOUR_BLUE,  COLOUR_GREEN},
      '{COLOUR_GREEN, COLOUR_BLUE,  COLOUR_RED,   COLOUR_GREEN},
      '{COLOUR_BLUE,  COLOUR_GREEN, COLOUR_GREEN, COLOUR_RED}
   };

   // Per output pixel: colours and column-edge flags for the window taps
   typedef struct packed {
      colour_type native;
      colour_type neighbor;
      logic       left_edge;   // column 0
      logic       left_next;   // column 1
      logic       right_next;  // column width-2
      logic       right_edge;  // column width-1
      logic       eol;
      logic       eof;
   } out_meta_type;

   // (a + b) mod 5 for a below 5 and b up to 5
   function automatic logic [2:0] add_mod5(input logic [2:0] a, input logic [2:0] b);
      logic [3:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         if (s >= 4'd5) begin
            s = s - 4'd5;
         end
         return s[2:0];
      end
   endfunction

endpackage

// File: rtl/bayer_demosaic_linear_5x5_unit.sv
// Bayer demosaic top level: line memories, 5x5 window and gradient-corrected kernels.
//
// Usage:
//  - req channel (valid/ready): one beat per raw Bayer sample in raster order
//    (req_func = pixel), then drain beats (req_func = drain) after the frame's last
//    sample to push out the 2*width+2 lagging output pixels.
//  - rsp channel (valid/ready): one RGB pixel per beat in raster order, with
//    end_of_line and end_of_frame flags.
//  - csr port: write-only; cfa_pattern, frame_width and frame_height are sampled
//    at the first pixel of each frame, so write them between frames.
//  - Output pixel n is produced by the beat carrying input pixel n + 2*width + 2
//    (or by a drain beat); rsp_valid rises when that beat reaches the result register,
//    after the memory read, window and kernel registers.
//  - Throughput: one beat per cycle on both sides while rsp_ready stays high. Every stage holds one beat, so
//    a stalled rsp only blocks req once all four stages are full.
//  - Reset clears the control registers, counters and pipeline valids; the line
//    memories and window hold stale data that is never read before it is written.
//  - A drain beat that arrives before the frame is complete, or after all of its
//    outputs left, is taken and dropped. A pixel after a complete frame starts a
//    new frame and drops any outputs not yet drained.
module bayer_demosaic_linear_5x5_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [PIXEL_BITS-1:0]             req_raw_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [PIXEL_BITS-1:0]             rsp_red,
   output logic [PIXEL_BITS-1:0]             rsp_green,
   output logic [PIXEL_BITS-1:0]             rsp_blue,
   output logic                              rsp_end_of_line,
   output logic                              rsp_end_of_frame,
   input  logic                              csr_write_en,
   input  logic [1:0]                        csr_index,
   input  logic [bdl_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import bdl_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int LW = AW + 1;
   localparam int CW = (LW > WIDTH_REG_BITS) ? LW : WIDTH_REG_BITS;
   localparam int PB = PIXEL_BITS;
   localparam int SW = PIXEL_BITS + 7;
   localparam logic [LW-1:0] LAT_W_RESET =
      LW'((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH);

   // ---------------------------------------------------------------- helpers
   function automatic logic [LW-1:0] clamp_width(input logic [WIDTH_REG_BITS-1:0] w);
      logic [CW-1:0] x;
      begin
         x = CW'(w);
         if (x < CW'(MIN_SIZE)) begin
            x = CW'(MIN_SIZE);
         end else if (x > CW'(MAX_WIDTH)) begin
            x = CW'(MAX_WIDTH);
         end
         return x[LW-1:0];
      end
   endfunction

   function automatic logic [HEIGHT_BITS-1:0] clamp_height(input logic [HEIGHT_BITS-1:0] h);
      logic [HEIGHT_BITS-1:0] x;
      begin
         x = h;
         if (x < HEIGHT_BITS'(MIN_SIZE)) begin
            x = HEIGHT_BITS'(MIN_SIZE);
         end else if (x > HEIGHT_BITS'(MAX_HEIGHT)) begin
            x = HEIGHT_BITS'(MAX_HEIGHT);
         end
         return x;
      end
   endfunction

   // Divide sixteenths by 16, round half to even, saturate to the pixel range
   function automatic logic [PB-1:0] round_sat(input logic signed [SW-1:0] s);
      logic [SW-5:0] q;
      logic [SW-4:0] qr;
      logic [3:0]    rem;
      logic          up;
      begin
         q   = s[SW-1:4];
         rem = s[3:0];
         up  = (rem > 4'd8) || ((rem == 4'd8) && q[0]);
         qr  = {1'b0, q} + (SW-3)'(up);
         if (s <= SW'(8)) begin
            return '0;
         end else if (qr > (SW-3)'((1 << PB) - 1)) begin
            return '1;
         end
         return qr[PB-1:0];
      end
   endfunction

   // ---------------------------------------------------------------- control registers
   logic [1:0]                cfg_cfa_ff;
   logic [WIDTH_REG_BITS-1:0] cfg_width_ff;
   logic [HEIGHT_BITS-1:0]    cfg_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cfa_ff    <= 2'd0;
         cfg_width_ff  <= WIDTH_REG_BITS'(RESET_WIDTH);
         cfg_height_ff <= HEIGHT_BITS'(RESET_HEIGHT);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CFA_PATTERN:  cfg_cfa_ff    <= csr_data[1:0];
            CSR_FRAME_WIDTH:  cfg_width_ff  <= csr_data[WIDTH_REG_BITS-1:0];
            CSR_FRAME_HEIGHT: cfg_height_ff <= csr_data[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- pipeline handshake
   logic s1_v_ff, s2_v_ff, s3_v_ff, rsp_v_ff;
   logic s1_go, s2_go, s3_go;
   logic accept;

   // Each stage moves when the one after it is empty or moving
   assign s3_go     = s3_v_ff && (!rsp_v_ff || rsp_ready);
   assign s2_go     = s2_v_ff && (!s3_v_ff || s3_go);
   assign s1_go     = s1_v_ff && (!s2_v_ff || s2_go);
   assign req_ready = !s1_v_ff || s1_go;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------- frame position
   // v_* is the write position; it runs on past the frame during drain so the
   // fetch column keeps sliding.
   logic [HEIGHT_BITS-1:0] vrow_ff, vrow_in;
   logic [AW-1:0]          vcol_ff, vcol_in;
   logic [2:0]             vline_ff, vline_in;
   logic [HEIGHT_BITS-1:0] orow_ff, orow_in;
   logic [AW-1:0]          ocol_ff, ocol_in;
   logic [1:0]             lat_cfa_ff, lat_cfa_in;
   logic [LW-1:0]          lat_w_ff, lat_w_in;
   logic [HEIGHT_BITS-1:0] lat_h_ff, lat_h_in;

   logic                   is_pixel, complete, restart, emit_dr, emit_px, advance, emit;
   logic [HEIGHT_BITS-1:0] er, orow_e;
   logic [AW-1:0]          ec, ocol_e;
   logic [2:0]             el;
   logic [2:0]             shift_code [LINES];
   logic [2:0]             fetch_line [LINES];
   logic [LINES-1:0]       fetch_byp;
   logic [1:0]             phase;
   out_meta_type           meta;

   always_comb begin
      is_pixel = (req_func == FUNC_PIXEL);
      complete = (vrow_ff >= lat_h_ff);
      restart  = is_pixel && (complete || ((vrow_ff == '0) && (vcol_ff == '0)));

      lat_cfa_in = restart ? cfg_cfa_ff : lat_cfa_ff;
      lat_w_in   = restart ? clamp_width(cfg_width_ff) : lat_w_ff;
      lat_h_in   = restart ? clamp_height(cfg_height_ff) : lat_h_ff;
      er         = restart ? '0 : vrow_ff;
      ec         = restart ? '0 : vcol_ff;
      el         = restart ? '0 : vline_ff;
      orow_e     = restart ? '0 : orow_ff;
      ocol_e     = restart ? '0 : ocol_ff;

      emit_dr = !is_pixel && complete && (orow_ff < lat_h_ff);
      emit_px = is_pixel &&
                ((er >= HEIGHT_BITS'(3)) || ((er == HEIGHT_BITS'(2)) && (ec >= AW'(2))));
      advance = is_pixel || emit_dr;
      emit    = is_pixel ? emit_px : emit_dr;

      // Next write position
      if ((LW'(ec) + LW'(1)) == lat_w_in) begin
         vcol_in  = '0;
         vrow_in  = er + HEIGHT_BITS'(1);
         vline_in = add_mod5(el, 3'd1);
      end else begin
         vcol_in  = ec + AW'(1);
         vrow_in  = er;
         vline_in = el;
      end

      // Next output position
      if ((LW'(ocol_e) + LW'(1)) == lat_w_in) begin
         ocol_in = '0;
         orow_in = orow_e + HEIGHT_BITS'(1);
      end else begin
         ocol_in = ocol_e + AW'(1);
         orow_in = orow_e;
      end

      // Row mirror for the fetched column, centered two rows above the write
      // row. Codes are row offset + 3, added mod 5 to the write line.
      priority if (er == HEIGHT_BITS'(2)) begin
         shift_code = '{3'd5, 3'd4, 3'd3, 3'd4, 3'd5};
      end else if (er == HEIGHT_BITS'(3)) begin
         shift_code = '{3'd3, 3'd2, 3'd3, 3'd4, 3'd5};
      end else if (er == lat_h_in) begin
         shift_code = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd3};
      end else if (er == (lat_h_in + HEIGHT_BITS'(1))) begin
         shift_code = '{3'd1, 3'd2, 3'd3, 3'd2, 3'd1};
      end else begin
         shift_code = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
      end
      for (int r = 0; r < LINES; r++) begin
         fetch_line[r] = add_mod5(el, shift_code[r]);
         // Only the row being written lands on the write line: forward it
         fetch_byp[r]  = is_pixel && (fetch_line[r] == el);
      end

      phase           = {orow_e[0], ocol_e[0]};
      meta.native     = PHASE_COLOUR[lat_cfa_in][phase];
      meta.neighbor   = PHASE_COLOUR[lat_cfa_in][phase ^ 2'b01];
      meta.left_edge  = (ocol_e == '0);
      meta.left_next  = (ocol_e == AW'(1));
      meta.right_next = (LW'(ocol_e) == (lat_w_in - LW'(2)));
      meta.right_edge = (LW'(ocol_e) == (lat_w_in - LW'(1)));
      meta.eol        = meta.right_edge;
      meta.eof        = meta.right_edge && (orow_e == (lat_h_in - HEIGHT_BITS'(1)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vrow_ff    <= '0;
         vcol_ff    <= '0;
         vline_ff   <= '0;
         orow_ff    <= '0;
         ocol_ff    <= '0;
         lat_cfa_ff <= 2'd0;
         lat_w_ff   <= LAT_W_RESET;
         lat_h_ff   <= HEIGHT_BITS'(RESET_HEIGHT);
      end else if (accept && advance) begin
         vrow_ff    <= vrow_in;
         vcol_ff    <= vcol_in;
         vline_ff   <= vline_in;
         lat_cfa_ff <= lat_cfa_in;
         lat_w_ff   <= lat_w_in;
         lat_h_ff   <= lat_h_in;
         if (emit) begin
            orow_ff <= orow_in;
            ocol_ff <= ocol_in;
         end else begin
            orow_ff <= orow_e;
            ocol_ff <= ocol_e;
         end
      end
   end

   // ---------------------------------------------------------------- stage 1: line memories
   logic [PB-1:0]    s1_rd_ff [LINES];
   logic [2:0]       s1_line_ff [LINES];
   logic [LINES-1:0] s1_byp_ff;
   logic [PB-1:0]    s1_pix_ff;
   logic             s1_emit_ff;
   out_meta_type     s1_meta_ff;

   for (genvar g = 0; g < LINES; g++) begin : g_line
      logic [PB-1:0] line_mem [MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (accept && advance) begin
            if (is_pixel && (el == 3'(g))) begin
               line_mem[ec] <= req_raw_pixel;
            end
            s1_rd_ff[g] <= line_mem[ec];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (accept && advance) begin
         s1_v_ff <= 1'b1;
      end else if (s1_go) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && advance) begin
         s1_line_ff <= fetch_line;
         s1_byp_ff  <= fetch_byp;
         s1_pix_ff  <= req_raw_pixel;
         s1_emit_ff <= emit;
         s1_meta_ff <= meta;
      end
   end

   // ---------------------------------------------------------------- stage 2: 5x5 window
   // win_ff[age][row]: age 0 is the newest column.
   logic [PB-1:0] win_ff [5][LINES];
   logic [PB-1:0] col_in [LINES];
   out_meta_type  s2_meta_ff;

   always_comb begin
      for (int r = 0; r < LINES; r++) begin
         col_in[r] = s1_byp_ff[r] ? s1_pix_ff : s1_rd_ff[s1_line_ff[r]];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         win_ff[0] <= col_in;
         for (int k = 1; k < 5; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
         s2_meta_ff <= s1_meta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s1_go) begin
         // Columns that only fill the window drop out here
         s2_v_ff <= s1_emit_ff;
      end else if (s2_go) begin
         s2_v_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- stage 3: kernels
   logic signed [SW-1:0] tp [LINES][5];
   logic signed [SW-1:0] sum_green, sum_cross, sum_row, sum_col, sum_native;
   logic signed [SW-1:0] sum_r_in, sum_g_in, sum_b_in;
   logic signed [SW-1:0] diag, far_v, far_h;
   logic signed [SW-1:0] s3_sum_r_ff, s3_sum_g_ff, s3_sum_b_ff;
   logic                 s3_eol_ff, s3_eof_ff;

   always_comb begin
      // Column taps with mirrored edges (no repeat of the edge sample)
      for (int r = 0; r < LINES; r++) begin
         for (int j = 0; j < 5; j++) begin
            tp[r][j] = $signed(SW'(win_ff[4-j][r]));
         end
         if (s2_meta_ff.left_edge) begin
            tp[r][0] = $signed(SW'(win_ff[0][r]));
            tp[r][1] = $signed(SW'(win_ff[1][r]));
         end
         if (s2_meta_ff.left_next) begin
            tp[r][0] = $signed(SW'(win_ff[2][r]));
         end
         if (s2_meta_ff.right_next) begin
            tp[r][4] = $signed(SW'(win_ff[2][r]));
         end
         if (s2_meta_ff.right_edge) begin
            tp[r][3] = $signed(SW'(win_ff[3][r]));
            tp[r][4] = $signed(SW'(win_ff[4][r]));
         end
      end

      diag  = tp[1][1] + tp[1][3] + tp[3][1] + tp[3][3];
      far_v = tp[0][2] + tp[4][2];
      far_h = tp[2][0] + tp[2][4];

      sum_native = tp[2][2] <<< 4;
      sum_green  = (tp[2][2] <<< 3)
                 + ((tp[1][2] + tp[3][2] + tp[2][1] + tp[2][3]) <<< 2)
                 - ((far_v + far_h) <<< 1);
      sum_cross  = (tp[2][2] <<< 3) + (tp[2][2] <<< 2) + (diag <<< 2)
                 - ((far_v + far_h) <<< 1) - (far_v + far_h);
      sum_row    = (tp[2][2] <<< 3) + (tp[2][2] <<< 1)
                 + ((tp[2][1] + tp[2][3]) <<< 3)
                 - (diag <<< 1) - (far_h <<< 1) + far_v;
      sum_col    = (tp[2][2] <<< 3) + (tp[2][2] <<< 1)
                 + ((tp[1][2] + tp[3][2]) <<< 3)
                 - (diag <<< 1) - (far_v <<< 1) + far_h;

      // Keep the native colour, fill the other two by phase
      unique case (s2_meta_ff.native)
         COLOUR_RED: begin
            sum_r_in = sum_native;
            sum_g_in = sum_green;
            sum_b_in = sum_cross;
         end
         COLOUR_BLUE: begin
            sum_r_in = sum_cross;
            sum_g_in = sum_green;
            sum_b_in = sum_native;
         end
         default: begin
            sum_g_in = sum_native;
            if (s2_meta_ff.neighbor == COLOUR_RED) begin
               sum_r_in = sum_row;
               sum_b_in = sum_col;
            end else begin
               sum_r_in = sum_col;
               sum_b_in = sum_row;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         s3_sum_r_ff <= sum_r_in;
         s3_sum_g_ff <= sum_g_in;
         s3_sum_b_ff <= sum_b_in;
         s3_eol_ff   <= s2_meta_ff.eol;
         s3_eof_ff   <= s2_meta_ff.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s2_go) begin
         s3_v_ff <= 1'b1;
      end else if (s3_go) begin
         s3_v_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- result register
   logic [PB-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic          rsp_eol_ff, rsp_eof_ff;

   always_ff @(posedge clock) begin
      if (s3_go) begin
         rsp_red_ff   <= round_sat(s3_sum_r_ff);
         rsp_green_ff <= round_sat(s3_sum_g_ff);
         rsp_blue_ff  <= round_sat(s3_sum_b_ff);
         rsp_eol_ff   <= s3_eol_ff;
         rsp_eof_ff   <= s3_eof_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (s3_go) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_v_ff;
   assign rsp_red          = rsp_red_ff;
   assign rsp_green        = rsp_green_ff;
   assign rsp_blue         = rsp_blue_ff;
   assign rsp_end_of_line  = rsp_eol_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the 5x5 linear Bayer demosaic unit.
`timescale 1ns / 1ps

module tb;
   import bdl_pkg::*;

   localparam int MAX_W = 2048;
   localparam int STALL_LIMIT = 4000;

   typedef enum int {
      KER_GREEN = 0,
      KER_CROSS = 1,
      KER_ROW   = 2,
      KER_COL   = 3
   } kernel_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       eol;
      logic       eof;
   } rgb_pixel_type;

   // Gradient-corrected kernels in sixteenths, [kernel][dy+2][dx+2]
   localparam int KERNELS [4][5][5] = '{
      '{'{0, 0, -2, 0, 0}, '{0, 0, 4, 0, 0}, '{-2, 4, 8, 4, -2},
        '{0, 0, 4, 0, 0}, '{0, 0, -2, 0, 0}},
      '{'{0, 0, -3, 0, 0}, '{0, 4, 0, 4, 0}, '{-3, 0, 12, 0, -3},
        '{0, 4, 0, 4, 0}, '{0, 0, -3, 0, 0}},
      '{'{0, 0, 1, 0, 0}, '{0, -2, 0, -2, 0}, '{-2, 8, 10, 8, -2},
        '{0, -2, 0, -2, 0}, '{0, 0, 1, 0, 0}},
      '{'{0, 0, -2, 0, 0}, '{0, -2, 8, -2, 0}, '{1, 0, 10, 0, 1},
        '{0, -2, 8, -2, 0}, '{0, 0, -2, 0, 0}}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_func;
   logic [7:0]               req_raw_pixel;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [7:0]               rsp_red;
   logic [7:0]               rsp_green;
   logic [7:0]               rsp_blue;
   logic                     rsp_end_of_line;
   logic                     rsp_end_of_frame;
   logic                     csr_write_en;
   logic [1:0]               csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   bayer_demosaic_linear_5x5_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_raw_pixel    (req_raw_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_end_of_line  (rsp_end_of_line),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow state of the demosaic
   logic [7:0]    line_mem [LINES*MAX_W];
   int unsigned   in_col, in_row, out_col, out_row;
   int unsigned   reg_cfa, reg_width, reg_height;
   int unsigned   frame_cfa, frame_width, frame_height;
   rgb_pixel_type pending_pixels [$];

   int  error_count = 0;
   int  beats_sent = 0;
   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   int  hold_request = 0;
   int  hold_left = 0;
   int  stall_count = 0;
   bit  req_fire_seen;

   function automatic int mirror_index(input int i, input int n);
      if (i < 0) i = -i;
      if (i >= n) i = 2 * n - 2 - i;
      if (i < 0) i = 0;
      if (i >= n) i = n - 1;
      return i;
   endfunction

   function automatic int tap(input int r, input int c);
      int rr;
      int cc;
      rr = mirror_index(r, frame_height);
      cc = mirror_index(c, frame_width);
      return int'(line_mem[(rr % LINES) * MAX_W + cc]);
   endfunction

   // Weighted window sum, divided by 16 with ties to even, saturated
   function automatic logic [7:0] apply_kernel(input kernel_type k, input int r, input int c);
      int          acc;
      int unsigned q;
      int unsigned rem;
      acc = 0;
      for (int dy = 0; dy < 5; dy++)
         for (int dx = 0; dx < 5; dx++)
            if (KERNELS[k][dy][dx] != 0)
               acc += KERNELS[k][dy][dx] * tap(r + dy - 2, c + dx - 2);
      if (acc <= 8) return 8'd0;
      q = acc >> 4;
      rem = acc & 15;
      if (rem > 8 || (rem == 8 && q[0])) q++;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic void emit_pixel();
      rgb_pixel_type px;
      int            r;
      int            c;
      int            ph;
      colour_type    native;
      colour_type    nbr;
      r = out_row;
      c = out_col;
      ph = ((out_row & 1) << 1) | (out_col & 1);
      native = PHASE_COLOUR[frame_cfa][ph];
      nbr = PHASE_COLOUR[frame_cfa][ph ^ 1];
      if (native == COLOUR_RED) begin
         px.red = 8'(tap(r, c));
         px.green = apply_kernel(KER_GREEN, r, c);
         px.blue = apply_kernel(KER_CROSS, r, c);
      end else if (native == COLOUR_BLUE) begin
         px.blue = 8'(tap(r, c));
         px.green = apply_kernel(KER_GREEN, r, c);
         px.red = apply_kernel(KER_CROSS, r, c);
      end else begin
         px.green = 8'(tap(r, c));
         if (nbr == COLOUR_RED) begin
            px.red = apply_kernel(KER_ROW, r, c);
            px.blue = apply_kernel(KER_COL, r, c);
         end else begin
            px.red = apply_kernel(KER_COL, r, c);
            px.blue = apply_kernel(KER_ROW, r, c);
         end
      end
      px.eol = (out_col == frame_width - 1);
      px.eof = (out_col == frame_width - 1) && (out_row == frame_height - 1);
      pending_pixels.push_back(px);
      out_col++;
      if (out_col >= frame_width) begin
         out_col = 0;
         out_row++;
      end
   endfunction

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      return (v < MIN_SIZE) ? MIN_SIZE : ((v > hi) ? hi : v);
   endfunction

   // Advance the shadow state by one accepted beat
   function automatic void predict_beat(input logic func, input logic [7:0] pix);
      if (func == FUNC_DRAIN) begin
         if (in_row >= frame_height && out_row < frame_height) emit_pixel();
         return;
      end
      if (in_row >= frame_height) begin
         in_row = 0;
         in_col = 0;
         out_row = 0;
         out_col = 0;
      end
      if (in_row == 0 && in_col == 0) begin
         frame_cfa = reg_cfa;
         frame_width = clamp_size(reg_width, MAX_W);
         frame_height = clamp_size(reg_height, MAX_HEIGHT);
         out_row = 0;
         out_col = 0;
      end
      line_mem[(in_row % LINES) * MAX_W + in_col] = pix;
      in_col++;
      if (in_col >= frame_width) begin
         in_col = 0;
         in_row++;
      end
      if (out_row < frame_height &&
          in_row * frame_width + in_col >=
          out_row * frame_width + out_col + 2 * frame_width + 3)
         emit_pixel();
   endfunction

   // Snapshot handshakes at the falling edge; everything is driven at the rising edge,
   // so these values hold through the next rising edge.
   always @(negedge clock) begin
      rgb_pixel_type want;
      req_fire_seen = !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
                     rsp_red, rsp_green, rsp_blue);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_red !== want.red || rsp_green !== want.green ||
                rsp_blue !== want.blue || rsp_end_of_line !== want.eol ||
                rsp_end_of_frame !== want.eof) begin
               $display("%0t: expected r=%0d g=%0d b=%0d eol=%0b eof=%0b, got r=%0d g=%0d b=%0d eol=%0b eof=%0b",
                        $realtime, want.red, want.green, want.blue, want.eol, want.eof,
                        rsp_red, rsp_green, rsp_blue, rsp_end_of_line, rsp_end_of_frame);
               error_count++;
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when a test asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Watchdog: count cycles where no beat moves on either side
   always @(posedge clock) begin
      if (reset || req_fire_seen || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Offer one beat, holding it until accepted; returns at the accepting edge
   task automatic send_beat(input logic func, input logic [7:0] pix);
      int gap;
      if ($urandom_range(99) < tx_idle_pct) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_raw_pixel <= pix;
      do begin
         @(posedge clock);
      end while (!req_fire_seen);
      predict_beat(func, pix);
      beats_sent++;
   endtask

   task automatic lower_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold until every predicted pixel has left, then let the pipeline settle
   task automatic wait_drained();
      lower_valid();
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int unsigned value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_CFA_PATTERN:  reg_cfa = value & 3;
         CSR_FRAME_WIDTH:  reg_width = value & 12'hFFF;
         CSR_FRAME_HEIGHT: reg_height = value & 13'h1FFF;
         default: ;
      endcase
   endtask

   function automatic logic [7:0] frame_sample(input int mode, input int r, input int c);
      case (mode)
         0: return 8'($urandom_range(255));
         1: return ($urandom_range(1)) ? 8'd255 : 8'd0;
         2: return ((r + c) & 1) ? 8'd255 : 8'd0;
         default: return 8'((r * 16 + c * 8) & 255);
      endcase
   endfunction

   // Configure when idle, stream one frame, then a number of drain beats.
   // early_pct inserts drain beats mid-frame, which must produce nothing.
   task automatic run_frame(input int unsigned cfa, input int unsigned w_cfg,
                            input int unsigned h_cfg, input int mode,
                            input int drains, input int early_pct);
      int unsigned w;
      int unsigned h;
      wait_drained();
      write_reg(CSR_CFA_PATTERN, cfa);
      write_reg(CSR_FRAME_WIDTH, w_cfg);
      write_reg(CSR_FRAME_HEIGHT, h_cfg);
      w = clamp_size(w_cfg & 12'hFFF, MAX_W);
      h = clamp_size(h_cfg & 13'h1FFF, MAX_HEIGHT);
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++) begin
            if ($urandom_range(99) < early_pct)
               send_beat(FUNC_DRAIN, 8'($urandom_range(255)));
            send_beat(FUNC_PIXEL, frame_sample(mode, r, c));
         end
      for (int i = 0; i < drains; i++) send_beat(FUNC_DRAIN, 8'($urandom_range(255)));
   endtask

   task automatic test_early_drain();
      // nothing received yet: drains are dropped
      send_beat(FUNC_DRAIN, 8'hFF);
      send_beat(FUNC_DRAIN, 8'h00);
   endtask

   task automatic test_patterns();
      // every Bayer order, with random 0/255 extremes and a checkerboard to hit saturation
      run_frame(0, 6, 6, 2, 14, 0);
      run_frame(1, 6, 6, 1, 14, 0);
      run_frame(2, 6, 6, 0, 14, 0);
      run_frame(3, 6, 6, 3, 14 + 3, 0);   // extra drains after the frame is out
   endtask

   task automatic test_sizes();
      run_frame(0, 0, 0, 0, 14, 0);       // clamp up to 6x6
      run_frame(1, 7, 9, 0, 16, 0);       // odd sizes
   endtask

   task automatic test_dropped_tail();
      // a new frame before the old one is fully drained drops the tail
      run_frame(1, 6, 6, 0, 5, 0);
      for (int i = 0; i < 36; i++) send_beat(FUNC_PIXEL, 8'($urandom_range(255)));
      for (int i = 0; i < 14; i++) send_beat(FUNC_DRAIN, 8'h00);
   endtask

   task automatic test_backpressure();
      run_frame(2, 6, 6, 0, 0, 0);
      hold_request = 300;                 // block output so the pipe fills
      for (int i = 0; i < 14; i++) send_beat(FUNC_DRAIN, 8'($urandom_range(255)));
      // pause after the frame until every pixel has left
      run_frame(3, 6, 6, 0, 0, 0);
      wait_drained();
      for (int i = 0; i < 14; i++) send_beat(FUNC_DRAIN, 8'($urandom_range(255)));
   endtask

   task automatic test_random(input int target);
      int stop_at;
      int drains;
      int unsigned w;
      int unsigned h;
      stop_at = beats_sent + target;
      while (beats_sent < stop_at) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 12);
         h = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 10);
         drains = 2 * clamp_size(w, MAX_W) + 2 + $urandom_range(2);
         if ($urandom_range(9) == 0) drains = $urandom_range(drains);
         run_frame($urandom_range(3), w, h, $urandom_range(3), drains, 3);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_PIXEL;
      req_raw_pixel <= '0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_CFA_PATTERN;
      csr_data <= '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      reg_cfa = 0;
      reg_width = RESET_WIDTH;
      reg_height = RESET_HEIGHT;
      frame_cfa = 0;
      frame_width = RESET_WIDTH;
      frame_height = RESET_HEIGHT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 15;
      rx_idle_pct = 60;
      test_early_drain();
      test_patterns();
      test_sizes();
      test_dropped_tail();
      test_backpressure();
      test_random(20);

      tx_idle_pct = 60;
      rx_idle_pct = 15;
      test_random(20);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random(20);

      wait_drained();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/bdl_pkg.sv
rtl/bayer_demosaic_linear_5x5_unit.sv
tb/sv/tb.sv
